// ----- hdl/rank_counting_insert_tree_defines.svh -----
// Assertion macros used by the rank counting insert tree controller.
`ifndef RANK_COUNTING_INSERT_TREE_DEFINES_SVH
`define RANK_COUNTING_INSERT_TREE_DEFINES_SVH

`ifndef SYNTH
// Holds at every clock edge outside reset.
`define RCIT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define RCIT_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RCIT_ASSERT(name, prop, msg)
`define RCIT_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ----- hdl/rcit_pkg.sv -----
// Package: types, codes and defaults of the rank counting insert tree.
`timescale 1ns / 1ps
`default_nettype none

package rcit_pkg;

   localparam int MAX_LEVELS_DEF = 16;
   localparam int COUNT_BITS_DEF = 32;

   localparam int LEVEL_W = 5;
   localparam logic [LEVEL_W-1:0] LEVELS_RESET = 5'd16;

   localparam logic [1:0] OP_GREATER = 2'd0;
   localparam logic [1:0] OP_SMALLER = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_CLEAR  = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] rank_count;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic issue_path;
      logic issue_child;
      logic clr_step;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       path_last;
      logic       has_child;
      logic       clr_last;
   } ctl_sts_type;

endpackage

`default_nettype wire

// ----- hdl/rcit_ctrl.sv -----
// Controller: sequences clear sweeps, tree walks and the result beat.
`timescale 1ns / 1ps
`default_nettype none
`include "rank_counting_insert_tree_defines.svh"

module rcit_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  rcit_pkg::ctl_sts_type     sts,
   output logic                      busy,
   output logic                      rsp_valid,
   output rcit_pkg::ctl_cmd_type     cmd
);
   import rcit_pkg::*;

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WALK  = 3'd2;
   localparam logic [2:0] ST_CHILD = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_CLEAR = 3'd5;
   localparam logic [2:0] ST_RESP  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (sts.kind)
                  KIND_INSERT: state_in = ST_WALK;
                  KIND_CLEAR:  state_in = ST_CLEAR;
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_WALK: begin
            cmd.issue_path = 1'b1;
            if (sts.path_last) begin
               state_in = sts.has_child ? ST_CHILD : ST_DRAIN;
            end
         end
         ST_CHILD: begin
            cmd.issue_child = 1'b1;
            state_in        = ST_DRAIN;
         end
         ST_DRAIN: begin
            // last read data is folded in this cycle
            state_in = ST_RESP;
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   `RCIT_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted beat did not raise busy")
   `RCIT_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid, "result strobe held two cycles")
   `RCIT_ASSERT_NEXT(a_resp_to_idle, state_ff == ST_RESP, state_ff == ST_IDLE, "no return to idle")
   `RCIT_ASSERT(a_drain_after_walk, (state_ff != ST_DRAIN) || ($past(state_ff) == ST_WALK) || ($past(state_ff) == ST_CHILD), "drain without walk")

endmodule

`default_nettype wire

// ----- hdl/rcit_dpath.sv -----
// Datapath: count store, path address generation and rank accumulation.
`timescale 1ns / 1ps
`default_nettype none

module rcit_dpath #(
   parameter int MAX_LEVELS = rcit_pkg::MAX_LEVELS_DEF,
   parameter int COUNT_BITS = rcit_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rcit_pkg::req_type             req_data,
   input  logic [rcit_pkg::LEVEL_W-1:0]  levels,
   input  rcit_pkg::ctl_cmd_type         cmd,
   output rcit_pkg::ctl_sts_type         sts,
   output rcit_pkg::rsp_type             rsp_data
);
   import rcit_pkg::*;

   localparam int NODE_W = MAX_LEVELS;
   localparam int DEPTH  = 2 ** NODE_W;
   localparam int HW     = $clog2(MAX_LEVELS + 1);

   logic [COUNT_BITS-1:0] mem [DEPTH];

   // request decode
   logic [LEVEL_W-1:0]     eff_l;
   logic                   out_of_range;
   logic [1:0]             kind;
   logic [NODE_W+15:0]     x_wide;
   logic [NODE_W-1:0]      root_node;
   logic [HW-1:0]          root_h;

   // walk state
   logic [NODE_W-1:0]     x_ff, node_ff, node_in, p_node_ff;
   logic [HW-1:0]         h_ff, h_in;
   logic                  greater_ff, root_ff, root_in;
   logic                  p_valid_ff, p_valid_in, p_child_ff, p_root_ff, p_take_ff;
   logic                  sub_ff, sub_in, full_ff, full_in;
   logic [COUNT_BITS-1:0] acc_ff, acc_in, rd_data_ff;
   logic [1:0]            status_ff, status_in;
   logic [NODE_W-1:0]     clr_cnt_ff;

   // path step
   logic [HW-1:0]         h_m1;
   logic [NODE_W-1:0]     half, next_node, child_node, rd_addr;
   logic                  path_last, go_left, take;

   // fold of read data
   logic                  full_now, path_wr, wr_en;
   logic [NODE_W-1:0]     wr_addr;
   logic [COUNT_BITS-1:0] wr_data, add_term, sub_term;
   logic [COUNT_BITS+31:0] acc_wide;

   always_comb begin
      if (levels == '0) begin
         eff_l = LEVEL_W'(1);
      end else if (levels > LEVEL_W'(MAX_LEVELS)) begin
         eff_l = LEVEL_W'(MAX_LEVELS);
      end else begin
         eff_l = levels;
      end
   end

   assign out_of_range = (req_data.value == 16'd0) || ((req_data.value >> eff_l) != 16'd0);

   always_comb begin
      unique case (req_data.operation) inside
         OP_CLEAR:               kind = KIND_CLEAR;
         OP_GREATER, OP_SMALLER: kind = out_of_range ? KIND_REJECT : KIND_INSERT;
         default:                kind = KIND_REJECT;
      endcase
   end

   assign x_wide    = {NODE_W'(0), req_data.value};
   assign root_node = NODE_W'(1) << (eff_l - LEVEL_W'(1));
   assign root_h    = HW'(eff_l - LEVEL_W'(1));

   // next node on the path and the final side child
   assign h_m1       = h_ff - HW'(1);
   assign half       = NODE_W'(1) << h_m1;
   assign path_last  = (x_ff == node_ff) || (h_ff == '0);
   assign go_left    = (x_ff < node_ff);
   assign take       = greater_ff ? go_left : !go_left;
   assign next_node  = go_left ? (node_ff - half) : (node_ff + half);
   assign child_node = greater_ff ? (node_ff + half) : (node_ff - half);
   assign rd_addr    = cmd.issue_child ? child_node : node_ff;

   // rank gets +count(node) - count(next) where the walk turns away from the side
   assign full_now = p_valid_ff && !p_child_ff && p_root_ff && (&rd_data_ff);
   assign path_wr  = p_valid_ff && !p_child_ff && !full_now && !full_ff;
   assign add_term = (p_valid_ff && (p_child_ff || p_take_ff)) ? rd_data_ff : '0;
   assign sub_term = (p_valid_ff && !p_child_ff && sub_ff) ? rd_data_ff : '0;

   assign wr_en   = cmd.clr_step || path_wr;
   assign wr_addr = cmd.clr_step ? clr_cnt_ff : p_node_ff;
   assign wr_data = cmd.clr_step ? '0 : (rd_data_ff + COUNT_BITS'(1));

   always_comb begin
      node_in    = node_ff;
      h_in       = h_ff;
      root_in    = root_ff;
      p_valid_in = cmd.issue_path || cmd.issue_child;
      acc_in     = acc_ff + add_term - sub_term;
      sub_in     = (p_valid_ff && !p_child_ff) ? p_take_ff : sub_ff;
      full_in    = full_ff || full_now;
      status_in  = full_now ? STATUS_FULL : status_ff;
      if (cmd.load) begin
         node_in   = root_node;
         h_in      = root_h;
         root_in   = 1'b1;
         acc_in    = '0;
         sub_in    = 1'b0;
         full_in   = 1'b0;
         status_in = (kind == KIND_REJECT) ? STATUS_RANGE : STATUS_OK;
      end else if (cmd.issue_path) begin
         root_in = 1'b0;
         if (!path_last) begin
            node_in = next_node;
            h_in    = h_m1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         clr_cnt_ff <= '0;
         full_ff    <= 1'b0;
         status_ff  <= STATUS_OK;
      end else begin
         p_valid_ff <= p_valid_in;
         full_ff    <= full_in;
         status_ff  <= status_in;
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + NODE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      h_ff    <= h_in;
      root_ff <= root_in;
      acc_ff  <= acc_in;
      sub_ff  <= sub_in;
      if (cmd.load) begin
         x_ff       <= x_wide[NODE_W-1:0];
         greater_ff <= (req_data.operation == OP_GREATER);
      end
      p_node_ff  <= node_ff;
      p_child_ff <= cmd.issue_child;
      p_root_ff  <= root_ff;
      p_take_ff  <= take && !path_last;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign acc_wide = {32'(0), acc_ff};

   assign sts.kind      = kind;
   assign sts.path_last = path_last;
   assign sts.has_child = (h_ff != '0);
   assign sts.clr_last  = &clr_cnt_ff;

   assign rsp_data.rank_count = (status_ff == STATUS_OK) ? acc_wide[31:0] : 32'd0;
   assign rsp_data.status     = status_ff;

endmodule

`default_nettype wire

// ----- hdl/rank_counting_insert_tree.sv -----
// Top level: level register, controller and datapath of the rank counting insert tree.
//
//   channel   ports                          handshake
//   request   start, busy, req_data          taken when start and not busy
//   result    rsp_valid, rsp_data            one-cycle strobe, no back-pressure
//   config    csr_write_en, csr_write_data   written on any edge with write enable
//
// An insert makes one store read per node on the path plus one for the side child, at
// most L reads together on the single read port, L being the level count in use, and
// fewer when the value sits high in the tree; then it passes the drain state, the result
// state and the idle state that takes the next beat. A rejected beat goes from idle
// straight to the result state. Clear sweeps the store one entry a cycle over all
// 2^MAX_LEVELS entries. After reset the same sweep runs with busy high.
// The result beat cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module rank_counting_insert_tree #(
   parameter int MAX_LEVELS = rcit_pkg::MAX_LEVELS_DEF,
   parameter int COUNT_BITS = rcit_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  rcit_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output rcit_pkg::rsp_type             rsp_data,
   input  logic                          csr_write_en,
   input  logic [rcit_pkg::LEVEL_W-1:0]  csr_write_data
);
   import rcit_pkg::*;

   logic [LEVEL_W-1:0] levels_ff;
   ctl_cmd_type        cmd;
   ctl_sts_type        sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
      end else if (csr_write_en) begin
         levels_ff <= csr_write_data;
      end
   end

   rcit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   rcit_dpath #(
      .MAX_LEVELS (MAX_LEVELS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .levels   (levels_ff),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ----- bench/rank_counting_insert_tree_chk.sv -----
// Checker: tracks the subtree counts, predicts each result beat and compares it.
`timescale 1ns / 1ps

module rank_counting_insert_tree_chk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  rcit_pkg::req_type             req_data,
   input  logic                          rsp_valid,
   input  rcit_pkg::rsp_type             rsp_data,
   input  logic                          csr_write_en,
   input  logic [rcit_pkg::LEVEL_W-1:0]  csr_write_data,
   output int                            fail_count,
   output int                            pending
);
   import rcit_pkg::*;

   localparam int NODES = 1 << MAX_LEVELS_DEF;

   logic [COUNT_BITS_DEF-1:0] node_count [NODES];
   logic [LEVEL_W-1:0]        level_reg = LEVELS_RESET;
   rsp_type                   rank_q [$];
   int                        mismatches = 0;

   // Walks from the root to the value's node, bumping every count on the path,
   // and sums the earlier items on the requested side of the value.
   function automatic rsp_type insert_and_rank(input req_type b);
      rsp_type                   r;
      int                        lv;
      int                        top;
      int                        h;
      int                        node;
      int                        nxt;
      logic                      want_gt;
      logic [COUNT_BITS_DEF-1:0] acc;
      r.rank_count = '0;
      r.status     = STATUS_OK;
      if (level_reg == 0)
         lv = 1;
      else if (level_reg > MAX_LEVELS_DEF)
         lv = MAX_LEVELS_DEF;
      else
         lv = int'(level_reg);
      top = (1 << lv) - 1;
      if (b.operation == OP_CLEAR) begin
         foreach (node_count[i])
            node_count[i] = '0;
         return r;
      end
      if (!(b.operation == OP_GREATER || b.operation == OP_SMALLER) ||
          b.value == 0 || int'(b.value) > top) begin
         r.status = STATUS_RANGE;
         return r;
      end
      if (&node_count[1 << (lv - 1)]) begin
         r.status = STATUS_FULL;
         return r;
      end
      want_gt = (b.operation == OP_GREATER);
      h       = lv - 1;
      node    = 1 << h;
      acc     = '0;
      while (int'(b.value) != node && h > 0) begin
         h = h - 1;
         if (int'(b.value) < node) begin
            nxt = node - (1 << h);
            if (want_gt)
               acc = acc + (node_count[node & (NODES - 1)] - node_count[nxt & (NODES - 1)]);
         end else begin
            nxt = node + (1 << h);
            if (!want_gt)
               acc = acc + (node_count[node & (NODES - 1)] - node_count[nxt & (NODES - 1)]);
         end
         node_count[node & (NODES - 1)] = node_count[node & (NODES - 1)] + 1'b1;
         node = nxt;
      end
      node_count[node & (NODES - 1)] = node_count[node & (NODES - 1)] + 1'b1;
      // value sits above the leaves: add the whole child subtree on that side
      if (h > 0) begin
         h = h - 1;
         if (want_gt)
            acc = acc + node_count[(node + (1 << h)) & (NODES - 1)];
         else
            acc = acc + node_count[(node - (1 << h)) & (NODES - 1)];
      end
      r.rank_count = acc[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (node_count[i])
            node_count[i] = '0;
         level_reg = LEVELS_RESET;
         rank_q.delete();
      end else begin
         // result beat first: a new beat accepted on this edge is younger
         if (rsp_valid) begin
            if (rank_q.size() == 0) begin
               $error("result beat with nothing expected: rank_count %0d status %0d",
                      rsp_data.rank_count, rsp_data.status);
               mismatches++;
            end else begin
               want = rank_q.pop_front();
               if (rsp_data.rank_count !== want.rank_count) begin
                  $error("rank_count: expected %0d, got %0d",
                         want.rank_count, rsp_data.rank_count);
                  mismatches++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatches++;
               end
            end
         end
         if (csr_write_en)
            level_reg = csr_write_data;
         if (start && !busy) begin
            want = insert_and_rank(req_data);
            rank_q.insert(rank_q.size(), want);
         end
      end
      fail_count <= mismatches;
      pending    <= rank_q.size();
   end

endmodule

// ----- bench/rank_counting_insert_tree_tb.sv -----
// Testbench top: clock, reset, request and level-register stimulus, final verdict.
`timescale 1ns / 1ps

module rank_counting_insert_tree_tb;
   import rcit_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         CYCLE_LIMIT  = 3_000_000;
   localparam int         DRAIN_CYCLES = 2 * (MAX_LEVELS_DEF + 4);
   localparam int         PHASES       = 14;
   localparam int         PHASE_ITEMS  = 45;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   logic               busy;
   req_type            req_data       = '0;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_write_en   = 1'b0;
   logic [LEVEL_W-1:0] csr_write_data = '0;
   int                 fail_count;
   int                 pending;
   int                 cycle_count    = 0;
   int                 burst_left     = 1;
   logic [LEVEL_W-1:0] level_plan [12] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2,
                                           5'd3, 5'd4, 5'd7, 5'd12, 5'd16, 5'd20};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   rank_counting_insert_tree u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   rank_counting_insert_tree_chk u_chk (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   // Returns once every expected beat is back and the block is free.
   task automatic wait_idle();
      do @(posedge clock); while (pending != 0 || busy);
   endtask

   // Holds one beat until taken; at the end of a burst drops start for a gap.
   task automatic send_beat(input logic [1:0] op, input logic [15:0] val);
      req_type b;
      b.operation = op;
      b.value     = val;
      start    <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (busy);
      burst_left--;
      if (burst_left == 0) begin
         start <= 1'b0;
         if ($urandom_range(0, 14) == 0)
            wait_idle();
         else
            repeat ($urandom_range(1, 25)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic write_levels(input logic [LEVEL_W-1:0] lv);
      csr_write_en   <= 1'b1;
      csr_write_data <= lv;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   initial begin
      logic [1:0]         op;
      logic [15:0]        val;
      logic [LEVEL_W-1:0] lv;
      int                 used;
      int                 top;
      int                 clear_at;
      int                 pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed, 16 levels, no idling
      burst_left = 40;
      send_beat(OP_GREATER, 16'h8000);
      send_beat(OP_SMALLER, 16'h0001);
      send_beat(OP_GREATER, 16'hFFFF);
      send_beat(OP_SMALLER, 16'hFFFF);
      send_beat(OP_GREATER, 16'h0001);
      send_beat(OP_SMALLER, 16'h8000);
      send_beat(OP_GREATER, 16'h8000);
      send_beat(OP_GREATER, 16'h4000);
      send_beat(OP_SMALLER, 16'hC000);
      send_beat(OP_GREATER, 16'h5555);
      send_beat(OP_SMALLER, 16'hAAAA);
      send_beat(OP_GREATER, 16'h0000);
      send_beat(OP_SMALLER, 16'h0000);
      send_beat(OP_UNUSED,  16'h0005);
      send_beat(OP_UNUSED,  16'hFFFF);
      send_beat(OP_CLEAR,   16'hFFFF);
      send_beat(OP_SMALLER, 16'h8000);
      send_beat(OP_GREATER, 16'h0001);
      send_beat(OP_SMALLER, 16'h7FFF);

      for (int ph = 0; ph < PHASES; ph++) begin
         start <= 1'b0;
         wait_idle();
         lv = (ph < 12) ? level_plan[ph] : LEVEL_W'($urandom_range(0, 31));
         write_levels(lv);
         // counts are kept across level changes; clear only in some phases
         used     = (lv == 0) ? 1 : (lv > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : int'(lv);
         top      = (1 << used) - 1;
         clear_at = (ph % 3 == 0) ? $urandom_range(0, PHASE_ITEMS - 1) : -1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            op   = (pick < 48) ? OP_GREATER : (pick < 96) ? OP_SMALLER : OP_UNUSED;
            if (i == clear_at)
               op = OP_CLEAR;
            pick = $urandom_range(0, 99);
            if (pick < 4)
               val = '0;
            else if (pick < 8)
               val = 16'($urandom);
            else if (pick < 14 && top < 16'hFFFF)
               val = 16'($urandom_range(top + 1, 16'hFFFF));
            else if (pick < 35)
               val = 16'($urandom_range(1, (top < 8) ? top : 8));
            else
               val = 16'($urandom_range(1, top));
            send_beat(op, val);
         end
      end

      start <= 1'b0;
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("rank_counting_insert_tree_tb OK");
      else
         $display("rank_counting_insert_tree_tb NOT OK");
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rank_counting_insert_tree_tb NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/rcit_pkg.sv
hdl/rcit_ctrl.sv
hdl/rcit_dpath.sv
hdl/rank_counting_insert_tree.sv
bench/rank_counting_insert_tree_chk.sv
bench/rank_counting_insert_tree_tb.sv
